[design/msss_pkg.sv]
// shared types and codes for the multi-stack shared store unit
package msss_pkg;

  localparam logic FN_PUSH = 1'b0;
  localparam logic FN_POP  = 1'b1;

  localparam logic [2:0] ST_PUSHED    = 3'd0;
  localparam logic [2:0] ST_POPPED    = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_UNDERFLOW = 3'd3;
  localparam logic [2:0] ST_BADSTACK  = 3'd4;

  typedef struct packed {
    logic capture;
    logic push_wr;
    logic pop_rd;
    logic pop_wr;
    logic err;
  } dp_cmd_t;

  typedef struct packed {
    logic is_pop;
    logic bad;
    logic fh_null;
    logic top_null;
    logic out_free;
  } dp_stat_t;

endpackage

[design/msss_ctrl.sv]
// sequencing state machine for push and pop operations
module msss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  msss_pkg::dp_stat_t stat,
  output msss_pkg::dp_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       fail;

  assign req_ready = (state == S_IDLE);
  assign fail = stat.bad || (stat.is_pop ? stat.top_null : stat.fh_null);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (fail) begin
          if (stat.out_free) begin
            cmd.err = 1'b1;
            state_next = S_IDLE;
          end
        end else if (stat.is_pop) begin
          cmd.pop_rd = 1'b1;
          state_next = S_POP;
        end else if (stat.out_free) begin
          cmd.push_wr = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_POP: begin
        if (stat.out_free) begin
          cmd.pop_wr = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[design/msss_dp.sv]
// stores, stack tops, free list head and result register
module msss_dp #(
  parameter int NUM_STACKS = 8,
  parameter int DEPTH      = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                func,
  input  logic [3:0]          stack_id,
  input  logic signed [31:0]  value,
  output logic [2:0]          status,
  output logic signed [31:0]  pop_data,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  input  msss_pkg::dp_cmd_t   cmd,
  output msss_pkg::dp_stat_t  stat
);

  localparam int PW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int IW = (SW > 4) ? SW : 4;
  localparam logic [PW-1:0] NIL = PW'(DEPTH);

  logic [31:0]   data_mem [2**AW];
  logic [PW-1:0] link_mem [2**AW];
  logic [PW-1:0] top_mem  [2**SW];
  logic [2**SW-1:0] top_valid;

  logic          func_r;
  logic [3:0]    id_r;
  logic [31:0]   value_r;
  logic [PW-1:0] free_head;
  logic [PW-1:0] fill;
  logic [PW-1:0] link_q;
  logic [PW-1:0] link_ra;
  logic [PW-1:0] top_q;
  logic [31:0]   data_q;

  logic [IW-1:0] id_in_m1;
  logic [IW-1:0] id_r_m1;
  logic [SW-1:0] idx_in;
  logic [SW-1:0] idx;
  logic [PW-1:0] top_cur;
  logic [PW-1:0] link_cur;
  logic [PW-1:0] link_cl;
  logic          bad;
  logic          fh_null;
  logic          top_null;
  logic          link_we;
  logic [AW-1:0] link_wa;
  logic [PW-1:0] link_wd;
  logic [AW-1:0] link_rd_a;
  logic          load;
  logic [2:0]    status_d;
  logic [31:0]   pop_data_d;

  assign id_in_m1 = IW'(stack_id) - IW'(1);
  assign id_r_m1  = IW'(id_r) - IW'(1);
  assign idx_in   = id_in_m1[SW-1:0];
  assign idx      = id_r_m1[SW-1:0];

  assign bad      = (id_r == 4'd0) || ({28'd0, id_r} > 32'(NUM_STACKS));
  assign top_cur  = top_valid[idx] ? top_q : NIL;
  assign top_null = (top_cur >= NIL);
  assign fh_null  = (free_head >= NIL);

  // slots beyond the fill mark still hold their reset link
  assign link_cur = (link_ra >= fill) ? PW'(link_ra + 1'b1) : link_q;
  assign link_cl  = (link_cur >= NIL) ? NIL : link_cur;

  assign stat.is_pop   = (func_r == msss_pkg::FN_POP);
  assign stat.bad      = bad;
  assign stat.fh_null  = fh_null;
  assign stat.top_null = top_null;
  assign stat.out_free = !rsp_valid || rsp_ready;

  assign link_we   = cmd.push_wr || cmd.pop_wr;
  assign link_wa   = cmd.push_wr ? free_head[AW-1:0] : top_cur[AW-1:0];
  assign link_wd   = cmd.push_wr ? top_cur : free_head;
  assign link_rd_a = cmd.capture ? free_head[AW-1:0] : top_cur[AW-1:0];

  assign load = cmd.push_wr || cmd.pop_wr || cmd.err;

  always_comb begin
    pop_data_d = 32'd0;
    if (cmd.pop_wr) begin
      status_d   = msss_pkg::ST_POPPED;
      pop_data_d = data_q;
    end else if (cmd.push_wr) begin
      status_d = msss_pkg::ST_PUSHED;
    end else if (bad) begin
      status_d = msss_pkg::ST_BADSTACK;
    end else if (func_r == msss_pkg::FN_POP) begin
      status_d = msss_pkg::ST_UNDERFLOW;
    end else begin
      status_d = msss_pkg::ST_OVERFLOW;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      data_mem[free_head[AW-1:0]] <= value_r;
    end
    if (cmd.pop_rd) begin
      data_q <= data_mem[top_cur[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (cmd.capture || cmd.pop_rd) begin
      link_q <= link_mem[link_rd_a];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      top_mem[idx] <= free_head;
    end else if (cmd.pop_wr) begin
      top_mem[idx] <= link_cl;
    end
    if (cmd.capture) begin
      top_q <= top_mem[idx_in];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= func;
      id_r    <= stack_id;
      value_r <= value;
      link_ra <= free_head;
    end else if (cmd.pop_rd) begin
      link_ra <= top_cur;
    end
    if (load) begin
      status   <= status_d;
      pop_data <= pop_data_d;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
      fill      <= '0;
      top_valid <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.push_wr) begin
        free_head      <= link_cl;
        top_valid[idx] <= 1'b1;
        if (free_head == fill) begin
          fill <= PW'(fill + 1'b1);
        end
      end else if (cmd.pop_wr) begin
        free_head      <= top_cur;
        top_valid[idx] <= 1'b1;
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

[design/multi_stack_shared_store_unit.sv]
// top level of the multi-stack shared store unit
// NUM_STACKS last-in-first-out stacks share one store of DEPTH linked slots,
// with free slots kept on a linked free list. One request beat (push or pop
// on a numbered stack) gives exactly one response beat carrying a status and,
// for a pop, the popped word. Push or error end in the look state, pop in the
// pop state, set by the dependent reads of the single-port link memory (top or
// free head first, then the link of that slot). One request is in flight at a
// time; a new request is taken while the previous response still waits in the
// output register. No clearing pass is needed after reset: a fill mark stands
// in for the initial free-list links of slots that were never written.
module multi_stack_shared_store_unit #(
  parameter int NUM_STACKS = 8,
  parameter int DEPTH      = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic               func,
  input  logic [3:0]         stack_id,
  input  logic signed [31:0] value,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [2:0]         status,
  output logic signed [31:0] pop_data
);

  msss_pkg::dp_cmd_t  cmd;
  msss_pkg::dp_stat_t stat;

  msss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  msss_dp #(
    .NUM_STACKS (NUM_STACKS),
    .DEPTH      (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .func      (func),
    .stack_id  (stack_id),
    .value     (value),
    .status    (status),
    .pop_data  (pop_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
